// ===== sv/pnf_pkg.sv =====
// ----------------------------------------------------------------------------
// pnf_pkg
// Shared types, defaults and helpers for the 2-D Perlin fBm noise block.
// ----------------------------------------------------------------------------
package pnf_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MAX_OCTAVES_DEF   = 8;
   localparam int FRAC_BITS_DEF     = 16;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SEED_W      = 32;
   localparam int OCT_CSR_W   = 4;
   localparam int COORD_W     = 32;
   localparam int NOISE_W     = 16;

   localparam int DIV_SH_W    = 32;
   localparam int DIV_CNT_W   = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD  = 6'd32;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NORM = 6'd16;

   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic CSR_SEED    = 1'b0;
   localparam logic CSR_OCTAVES = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_ctl_type;

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_FILL    = 14'b00000000000010,
      ST_SH_GEN  = 14'b00000000000100,
      ST_SH_DIV  = 14'b00000000001000,
      ST_SH_RDI  = 14'b00000000010000,
      ST_SH_RDJ  = 14'b00000000100000,
      ST_SH_WAIT = 14'b00000001000000,
      ST_SH_WRJ  = 14'b00000010000000,
      ST_RD      = 14'b00000100000000,
      ST_MUL     = 14'b00001000000000,
      ST_NORM    = 14'b00010000000000,
      ST_SCALE   = 14'b00100000000000,
      ST_DIV     = 14'b01000000000000,
      ST_DONE    = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      RS_X0, RS_X1, RS_H00, RS_H01, RS_H10, RS_H11, RS_TAIL
   } rd_step_type;

   typedef enum logic [3:0] {
      MS_TX2, MS_TX3, MS_TXW, MS_U,
      MS_TY2, MS_TY3, MS_TYW, MS_V,
      MS_LO, MS_HI, MS_MIX, MS_OUT
   } mul_step_type;

   typedef enum logic [2:0] {
      GR_XPY, GR_NXPY, GR_XMY, GR_NXMY, GR_X, GR_NX, GR_Y, GR_NY
   } grad_sel_type;

   function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

// ===== sv/pnf_div.sv =====
// ----------------------------------------------------------------------------
// pnf_div
// Restoring divider, one quotient bit per cycle, remainder preload.
// ----------------------------------------------------------------------------
module pnf_div #(
   parameter int DEN_W = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pnf_pkg::div_ctl_type           ctl,
   input  logic [DEN_W-1:0]               den,
   input  logic [DEN_W-1:0]               rem_init,
   input  logic [pnf_pkg::DIV_SH_W-1:0]   bits,
   output logic                           done,
   output logic [DEN_W-1:0]               rem,
   output logic [pnf_pkg::DIV_SH_W-1:0]   quo
);
   import pnf_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_SH_W-1:0]  sh_ff;

   logic [DEN_W:0]       rem_sh;
   logic [DEN_W:0]       rem_sub;
   logic                 fits;

   assign rem_sh  = {rem_ff, sh_ff[DIV_SH_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ctl.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= rem_init;
         den_ff <= den;
         sh_ff  <= bits;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         sh_ff  <= {sh_ff[DIV_SH_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;
   assign quo  = sh_ff;

`ifndef SYNTH
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not reduced");
`endif

endmodule

// ===== sv/perlin_noise_2d_fbm.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_2d_fbm
// 2-D Perlin noise summed over octaves, Q16.16 in, Q1.15 out, with a
// permutation table that a reseed transaction rebuilds from the seed register.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transfer
//  req     | req_valid/ready, op, x_coord, y_coord   | one transaction per item
//  rsp     | rsp_valid/ready, noise_value, was_reseed| one transaction per item
//  csr     | csr_psel/penable/pwrite/paddr/pwdata    | APB, seed @0, octaves @4
//
//  Sample: per octave, 6 table reads plus one capture step on the
//  single read port, then 12 multiplies through one shared multiplier;
//  plus accept, normalize, the 16-step division and the result; the
//  division is skipped when the result saturates.
//  Reseed: N fill writes, then per swap the 32-step modulo divider,
//  two reads and two writes, with N table entries.
//  Reset is synchronous; the table holds garbage until the first reseed.
//  A new transaction is taken once the previous result sits in the output
//  register; a stalled rsp holds the block at its final step.
// ----------------------------------------------------------------------------
module perlin_noise_2d_fbm #(
   parameter int TABLE_ENTRIES = pnf_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_OCTAVES   = pnf_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS     = pnf_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic signed [pnf_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [pnf_pkg::COORD_W-1:0] req_y_coord,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pnf_pkg::NOISE_W-1:0] rsp_noise_value,
   output logic                               rsp_was_reseed,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pnf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pnf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pnf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import pnf_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int SHF_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int OP_W   = F + 6;
   localparam int PR_W   = 2 * OP_W;
   localparam int ACC_W  = F + 4 + MAX_OCTAVES;
   localparam int NB_W   = ACC_W + 17;
   localparam int D_W    = F + MAX_OCTAVES;
   localparam int DEN_W  = (D_W > IDX_W + 1) ? D_W : IDX_W + 1;
   localparam int PX_W   = F + IDX_W;
   localparam int XW     = (PX_W > COORD_W) ? PX_W : COORD_W;

   localparam logic signed [OP_W-1:0] FX_ONE   = OP_W'(longint'(1) << F);
   localparam logic signed [OP_W-1:0] FX_TEN   = OP_W'(longint'(10) << F);
   localparam logic signed [OP_W-1:0] FX_FIFT  = OP_W'(longint'(15) << F);
   localparam logic signed [OP_W-1:0] FX_ROOT2 =
      OP_W'(((longint'(1414) << F) + 64'sd500) / 64'sd1000);
   localparam logic signed [PR_W-1:0] PR_HALF  = PR_W'(longint'(1) << (F - 1));

   // ---------------- CSR ----------------
   logic [SEED_W-1:0]    seed_ff;
   logic [OCT_CSR_W-1:0] octaves_ff;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= SEED_W'(1);
         octaves_ff <= OCT_CSR_W'(1);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_SEED:    seed_ff    <= csr_pwdata[SEED_W-1:0];
            CSR_OCTAVES: octaves_ff <= csr_pwdata[OCT_CSR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_SEED:    csr_prdata = CSR_DATA_W'(seed_ff);
         CSR_OCTAVES: csr_prdata = CSR_DATA_W'(octaves_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------- state ----------------
   state_type    state_ff, state_in;
   rd_step_type  rstep_ff;
   mul_step_type mstep_ff;
   logic         mphase_ff;

   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [OCT_W-1:0]  noct_ff;
   logic [SHF_W-1:0]  oct_ff;
   logic [IDX_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  i_ff, j_ff;
   logic [IDX_W-1:0]  pi_ff;
   logic [IDX_W-1:0]  p0_ff, p1_ff;
   logic [2:0]        h00_ff, h01_ff, h10_ff, h11_ff;
   logic [SEED_W-1:0] s_ff;

   logic signed [OP_W-1:0] t2_ff, t3_ff, w_ff, u_ff, v_ff, lo_ff, hi_ff, mix_ff;
   logic signed [PR_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [NB_W-1:0]  nb_ff;

   logic signed [NOISE_W-1:0] res_noise_ff;
   logic                      res_reseed_ff;
   logic                      rsp_valid_ff;
   logic signed [NOISE_W-1:0] rsp_noise_ff;
   logic                      rsp_reseed_ff;

   // ---------------- permutation memory ----------------
   logic [IDX_W-1:0] perm_mem [TABLE_ENTRIES];
   logic [IDX_W-1:0] perm_rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_wdata, mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_waddr] <= mem_wdata;
      end
      perm_rd_ff <= perm_mem[mem_raddr];
   end

   // ---------------- coordinates ----------------
   logic signed [XW-1:0] xe, ye, xs, ys;
   logic [IDX_W-1:0]     x0, x1, y0, y1;
   logic signed [OP_W-1:0] tx, ty, txm, tym;

   assign xe  = XW'(x_ff);
   assign ye  = XW'(y_ff);
   assign xs  = xe <<< oct_ff;
   assign ys  = ye <<< oct_ff;
   assign x0  = xs[PX_W-1:F];
   assign y0  = ys[PX_W-1:F];
   assign x1  = x0 + 1'b1;
   assign y1  = y0 + 1'b1;
   assign tx  = signed'(OP_W'(xs[F-1:0]));
   assign ty  = signed'(OP_W'(ys[F-1:0]));
   assign txm = tx - FX_ONE;
   assign tym = ty - FX_ONE;

   function automatic logic signed [OP_W-1:0] grad(input logic [2:0] h,
                                                   input logic signed [OP_W-1:0] gx,
                                                   input logic signed [OP_W-1:0] gy);
      logic signed [OP_W-1:0] g;
      unique case (grad_sel_type'(h))
         GR_XPY:  g = gx + gy;
         GR_NXPY: g = gy - gx;
         GR_XMY:  g = gx - gy;
         GR_NXMY: g = -gx - gy;
         GR_X:    g = gx;
         GR_NX:   g = -gx;
         GR_Y:    g = gy;
         GR_NY:   g = -gy;
         default: g = '0;
      endcase
      return g;
   endfunction

   logic signed [OP_W-1:0] g00, g10, g01, g11;
   assign g00 = grad(h00_ff, tx,  ty);
   assign g10 = grad(h10_ff, txm, ty);
   assign g01 = grad(h01_ff, tx,  tym);
   assign g11 = grad(h11_ff, txm, tym);

   // ---------------- shared multiplier ----------------
   logic signed [OP_W-1:0] mul_a, mul_b, add_v, mul_res;
   logic signed [PR_W-1:0] prod_c, prod_rnd;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      add_v = '0;
      unique case (mstep_ff)
         MS_TX2: begin mul_a = tx;    mul_b = tx; end
         MS_TX3: begin mul_a = t2_ff; mul_b = tx; end
         MS_TXW: begin
            mul_a = tx;
            mul_b = (tx <<< 2) + (tx <<< 1) - FX_FIFT;
            add_v = FX_TEN;
         end
         MS_U:   begin mul_a = t3_ff; mul_b = w_ff; end
         MS_TY2: begin mul_a = ty;    mul_b = ty; end
         MS_TY3: begin mul_a = t2_ff; mul_b = ty; end
         MS_TYW: begin
            mul_a = ty;
            mul_b = (ty <<< 2) + (ty <<< 1) - FX_FIFT;
            add_v = FX_TEN;
         end
         MS_V:   begin mul_a = t3_ff; mul_b = w_ff; end
         MS_LO:  begin mul_a = u_ff;  mul_b = g10 - g00;     add_v = g00;   end
         MS_HI:  begin mul_a = u_ff;  mul_b = g11 - g01;     add_v = g01;   end
         MS_MIX: begin mul_a = v_ff;  mul_b = hi_ff - lo_ff; add_v = lo_ff; end
         MS_OUT: begin mul_a = mix_ff; mul_b = FX_ROOT2; end
         default: ;
      endcase
   end

   assign prod_c   = PR_W'(mul_a) * PR_W'(mul_b);
   assign prod_rnd = (prod_ff + PR_HALF) >>> F;
   assign mul_res  = prod_rnd[OP_W-1:0] + add_v;

   // ---------------- normalization ----------------
   logic [OCT_W-1:0]        noct_sel;
   logic [MAX_OCTAVES:0]    pw;
   logic [MAX_OCTAVES:0]    pw_m1;
   logic [MAX_OCTAVES-1:0]  msk;
   logic [D_W-1:0]          dd;
   logic signed [NB_W-1:0]  half_den, lim, nb_c;
   logic [NB_W-1:0]         r_sum;
   logic                    sat_hi, sat_lo;

   always_comb begin
      if (octaves_ff == '0) begin
         noct_sel = OCT_W'(1);
      end else if (int'(octaves_ff) > MAX_OCTAVES) begin
         noct_sel = OCT_W'(MAX_OCTAVES);
      end else begin
         noct_sel = OCT_W'(octaves_ff);
      end
   end

   assign pw       = (MAX_OCTAVES + 1)'(1) << noct_ff;
   assign pw_m1    = pw - 1'b1;
   assign msk      = pw_m1[MAX_OCTAVES-1:0];
   assign dd       = {msk, {F{1'b0}}};
   assign half_den = signed'(NB_W'(msk) << (F - 1));
   assign lim      = signed'(NB_W'(dd) << 15);
   assign nb_c     = (NB_W'(acc_ff) <<< 15) + half_den;
   assign sat_hi   = nb_ff >= lim;
   assign sat_lo   = nb_ff < -lim;
   assign r_sum    = unsigned'(nb_ff + lim);

   // ---------------- divider ----------------
   div_ctl_type          div_ctl;
   logic [DEN_W-1:0]     div_den, div_rem_init, div_rem;
   logic [DIV_SH_W-1:0]  div_bits, div_quo;
   logic                 div_done;
   logic [IDX_W:0]       i_p1;

   assign i_p1 = {1'b0, i_ff} + 1'b1;

   always_comb begin
      div_ctl      = '0;
      div_den      = DEN_W'(i_p1);
      div_rem_init = '0;
      div_bits     = xorshift32(s_ff);
      if (state_ff == ST_SH_GEN) begin
         div_ctl.start = 1'b1;
         div_ctl.steps = DIV_STEPS_MOD;
      end else if (state_ff == ST_SCALE) begin
         div_ctl.start = !sat_hi && !sat_lo;
         div_ctl.steps = DIV_STEPS_NORM;
         div_den       = DEN_W'(dd);
         div_rem_init  = DEN_W'(r_sum[D_W+15:16]);
         div_bits      = {r_sum[15:0], 16'b0};
      end
   end

   pnf_div #(
      .DEN_W(DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .den     (div_den),
      .rem_init(div_rem_init),
      .bits    (div_bits),
      .done    (div_done),
      .rem     (div_rem),
      .quo     (div_quo)
   );

   // ---------------- memory port selection ----------------
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = cnt_ff;
      mem_raddr = i_ff;
      unique case (state_ff)
         ST_FILL:    mem_we = 1'b1;
         ST_SH_RDJ:  mem_raddr = j_ff;
         ST_SH_WAIT: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = perm_rd_ff;
         end
         ST_SH_WRJ: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = pi_ff;
         end
         ST_RD: begin
            unique case (rstep_ff)
               RS_X0:   mem_raddr = x0;
               RS_X1:   mem_raddr = x1;
               RS_H00:  mem_raddr = p0_ff + y0;
               RS_H01:  mem_raddr = p0_ff + y1;
               RS_H10:  mem_raddr = p1_ff + y0;
               RS_H11:  mem_raddr = p1_ff + y1;
               default: mem_raddr = i_ff;
            endcase
         end
         default: ;
      endcase
   end

   // ---------------- sequencer ----------------
   logic rsp_free;
   logic last_oct;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_oct  = (OCT_W'(oct_ff) + 1'b1) == noct_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_RESEED) ? ST_FILL : ST_RD;
            end
         end
         ST_FILL:    if (cnt_ff == IDX_W'(TABLE_ENTRIES - 1)) state_in = ST_SH_GEN;
         ST_SH_GEN:  state_in = ST_SH_DIV;
         ST_SH_DIV:  if (div_done) state_in = ST_SH_RDI;
         ST_SH_RDI:  state_in = ST_SH_RDJ;
         ST_SH_RDJ:  state_in = ST_SH_WAIT;
         ST_SH_WAIT: state_in = ST_SH_WRJ;
         ST_SH_WRJ:  state_in = (i_ff == IDX_W'(1)) ? ST_DONE : ST_SH_GEN;
         ST_RD:      if (rstep_ff == RS_TAIL) state_in = ST_MUL;
         ST_MUL: begin
            if (mphase_ff && mstep_ff == MS_OUT) begin
               state_in = last_oct ? ST_NORM : ST_RD;
            end
         end
         ST_NORM:    state_in = ST_SCALE;
         ST_SCALE:   state_in = (sat_hi || sat_lo) ? ST_DONE : ST_DIV;
         ST_DIV:     if (div_done) state_in = ST_DONE;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x_ff      <= req_x_coord;
            y_ff      <= req_y_coord;
            cnt_ff    <= '0;
            s_ff      <= (seed_ff == '0) ? SEED_W'(1) : seed_ff;
            noct_ff   <= noct_sel;
            oct_ff    <= '0;
            acc_ff    <= '0;
            rstep_ff  <= RS_X0;
            mstep_ff  <= MS_TX2;
            mphase_ff <= 1'b0;
         end
         ST_FILL: begin
            cnt_ff <= cnt_ff + 1'b1;
            i_ff   <= IDX_W'(TABLE_ENTRIES - 1);
         end
         ST_SH_GEN:  s_ff <= xorshift32(s_ff);
         ST_SH_DIV:  j_ff <= div_rem[IDX_W-1:0];
         ST_SH_RDJ:  pi_ff <= perm_rd_ff;
         ST_SH_WRJ: begin
            i_ff          <= i_ff - 1'b1;
            res_noise_ff  <= '0;
            res_reseed_ff <= 1'b1;
         end
         ST_RD: begin
            rstep_ff <= rd_step_type'(rstep_ff + 1'b1);
            unique case (rstep_ff)
               RS_X1:   p0_ff  <= perm_rd_ff;
               RS_H00:  p1_ff  <= perm_rd_ff;
               RS_H01:  h00_ff <= perm_rd_ff[2:0];
               RS_H10:  h01_ff <= perm_rd_ff[2:0];
               RS_H11:  h10_ff <= perm_rd_ff[2:0];
               RS_TAIL: h11_ff <= perm_rd_ff[2:0];
               default: ;
            endcase
         end
         ST_MUL: begin
            mphase_ff <= !mphase_ff;
            if (!mphase_ff) begin
               prod_ff <= prod_c;
            end else begin
               mstep_ff <= (mstep_ff == MS_OUT) ? MS_TX2 : mul_step_type'(mstep_ff + 1'b1);
               unique case (mstep_ff)
                  MS_TX2, MS_TY2: t2_ff <= mul_res;
                  MS_TX3, MS_TY3: t3_ff <= mul_res;
                  MS_TXW, MS_TYW: w_ff  <= mul_res;
                  MS_U:   u_ff   <= mul_res;
                  MS_V:   v_ff   <= mul_res;
                  MS_LO:  lo_ff  <= mul_res;
                  MS_HI:  hi_ff  <= mul_res;
                  MS_MIX: mix_ff <= mul_res;
                  MS_OUT: begin
                     acc_ff   <= (acc_ff <<< 1) + ACC_W'(mul_res);
                     oct_ff   <= oct_ff + 1'b1;
                     rstep_ff <= RS_X0;
                  end
                  default: ;
               endcase
            end
         end
         ST_NORM: nb_ff <= nb_c;
         ST_SCALE: begin
            res_reseed_ff <= 1'b0;
            if (sat_hi) begin
               res_noise_ff <= NOISE_W'(16'sh7fff);
            end else if (sat_lo) begin
               res_noise_ff <= NOISE_W'(16'sh8000);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_noise_ff <= signed'({~div_quo[15], div_quo[14:0]});
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_noise_ff  <= res_noise_ff;
               rsp_reseed_ff <= res_reseed_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;
   assign rsp_was_reseed  = rsp_reseed_ff;

`ifndef SYNTH
   a_no_write_in_sample: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_MUL || state_ff == ST_NORM ||
       state_ff == ST_SCALE || state_ff == ST_DIV) |-> !mem_we)
      else $error("table written during a sample");
   a_octave_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_MUL) |-> (OCT_W'(oct_ff) < noct_ff))
      else $error("octave index past octave count");
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SH_DIV || state_ff == ST_DIV))
      else $error("divider finished outside a wait state");
   a_reseed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reseed_ff) |-> (rsp_noise_ff == '0))
      else $error("reseed result carries nonzero noise");
`endif

endmodule

// ===== dv/tb_perlin_noise_2d_fbm.sv =====
// ----------------------------------------------------------------------------
// tb_perlin_noise_2d_fbm
// Self-checking bench for the 2-D Perlin fBm noise block: a bit-exact Q16.16
// noise predictor, random valid/ready gaps on both channels, APB register
// phases over seed and octave count, directed edges, then random traffic.
// ----------------------------------------------------------------------------
module tb_perlin_noise_2d_fbm;
   timeunit 1ns;
   timeprecision 1ps;
   import pnf_pkg::*;

   localparam int  N_RANDOM    = 2000;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam longint FX_ONE   = 64'sd65536;
   localparam longint FX_HALF  = 64'sd32768;
   localparam longint FX_ROOT2 = ((64'sd1414 <<< 16) + 64'sd500) / 64'sd1000;

   typedef struct {
      logic signed [NOISE_W-1:0] noise;
      logic                      reseed;
   } noise_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_op = OP_SAMPLE;
   logic signed [COORD_W-1:0]  req_x_coord = '0;
   logic signed [COORD_W-1:0]  req_y_coord = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [NOISE_W-1:0]  rsp_noise_value;
   logic                       rsp_was_reseed;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   logic [7:0]        perm [0:255];
   logic [SEED_W-1:0] seed_reg = 32'd1;
   logic [3:0]        octave_reg = 4'd1;

   noise_result_type pending_noise [$];
   int  errors = 0;
   int  cycles = 0;
   int  n_samples = 0;
   int  n_reseeds = 0;
   int  n_checked = 0;
   bit  no_idle = 1'b0;
   logic [15:0] octaves_seen = '0;

   perlin_noise_2d_fbm DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("perlin_noise_2d_fbm verification failed");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic longint fdiv(longint p, longint d);
      longint q;
      q = p / d;
      if (p % d < 0) q -= 1;
      return q;
   endfunction

   function automatic longint fxm(longint a, longint b);
      return (a * b + FX_HALF) >>> 16;
   endfunction

   function automatic longint fade(longint t);
      longint t2, t3, w;
      t2 = fxm(t, t);
      t3 = fxm(t2, t);
      w  = fxm(t, 6 * t - 15 * FX_ONE) + 10 * FX_ONE;
      return fxm(t3, w);
   endfunction

   function automatic longint lerp(longint a, longint b, longint t);
      return a + fxm(t, b - a);
   endfunction

   function automatic longint grad(logic [7:0] h, longint x, longint y);
      case (grad_sel_type'(h[2:0]))
         GR_XPY:  return x + y;
         GR_NXPY: return -x + y;
         GR_XMY:  return x - y;
         GR_NXMY: return -x - y;
         GR_X:    return x;
         GR_NX:   return -x;
         GR_Y:    return y;
         default: return -y;
      endcase
   endfunction

   function automatic logic [7:0] hash(logic [7:0] cx, logic [7:0] cy);
      logic [7:0] first;
      first = perm[cx];
      return perm[8'(first + cy)];
   endfunction

   function automatic longint perlin_octave(longint px, longint py);
      longint tx, ty, u, v, lo, hi;
      logic [7:0] x0, y0, x1, y1;
      tx = px & 64'hFFFF;
      ty = py & 64'hFFFF;
      x0 = 8'(px >>> 16);
      y0 = 8'(py >>> 16);
      x1 = x0 + 8'd1;
      y1 = y0 + 8'd1;
      u  = fade(tx);
      v  = fade(ty);
      lo = lerp(grad(hash(x0, y0), tx, ty), grad(hash(x1, y0), tx - FX_ONE, ty), u);
      hi = lerp(grad(hash(x0, y1), tx, ty - FX_ONE),
                grad(hash(x1, y1), tx - FX_ONE, ty - FX_ONE), u);
      return fxm(lerp(lo, hi, v), FX_ROOT2);
   endfunction

   function automatic void shuffle_table();
      logic [31:0] s;
      logic [7:0]  tmp;
      int          j;
      s = (seed_reg == 0) ? 32'd1 : seed_reg;
      for (int i = 0; i < 256; i++) perm[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         s = s ^ (s << 13);
         s = s ^ (s >> 17);
         s = s ^ (s << 5);
         j = int'(s % (i + 1));
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
   endfunction

   function automatic noise_result_type predict_noise(logic op, logic signed [31:0] x,
                                                      logic signed [31:0] y);
      noise_result_type r;
      longint acc, num, den, q;
      int n;
      r.reseed = 1'b0;
      r.noise  = '0;
      if (op == OP_RESEED) begin
         shuffle_table();
         r.reseed = 1'b1;
         return r;
      end
      n = (octave_reg == 0) ? 1 : (octave_reg > 8) ? 8 : int'(octave_reg);
      acc = 0;
      for (int i = 0; i < n; i++)
         acc += perlin_octave(longint'(x) <<< i, longint'(y) <<< i) <<< (n - 1 - i);
      num = acc <<< 15;
      den = ((64'sd1 <<< n) - 1) * FX_ONE;
      q = fdiv(num + den / 2, den);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.noise = 16'(q);
      return r;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_item(logic op, logic signed [31:0] x, logic signed [31:0] y);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op = op;
      req_x_coord = x;
      req_y_coord = y;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_noise.push_back(predict_noise(op, x, y));
      if (op == OP_RESEED) n_reseeds++;
      else begin
         n_samples++;
         octaves_seen[octave_reg] = 1'b1;
      end
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_noise.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] data);
      wait_drain();
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (idx == CSR_SEED) seed_reg = data;
      else octave_reg = data[3:0];
   endtask

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ---------------- checker ----------------
   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   always @(posedge clock) begin
      noise_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_noise.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_noise_value, 0);
         end else begin
            want = pending_noise.pop_front();
            n_checked++;
            if (rsp_noise_value !== want.noise)
               report_mismatch("noise_value", rsp_noise_value, want.noise);
            if (rsp_was_reseed !== want.reseed)
               report_mismatch("was_reseed", rsp_was_reseed, want.reseed);
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2: return 32'($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
         3: return {16'($urandom), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
         default: return $urandom_range(0, 1) ? 32'h7FFF0000 | 32'($urandom_range(0, 16'hFFFF))
                                             : 32'h80000000 | 32'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic test_directed();
      send_item(OP_RESEED, 0, 0);
      send_item(OP_SAMPLE, 0, 0);
      send_item(OP_SAMPLE, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(OP_SAMPLE, 32'h80000000, 32'h80000000);
      send_item(OP_SAMPLE, 32'h0000FFFF, 32'hFFFF0000);
      send_item(OP_SAMPLE, 32'h00010000, 32'hFFFFFFFF);
      send_item(OP_SAMPLE, 32'h00008000, 32'h00008000);
      csr_write(CSR_OCTAVES, 32'd0);
      send_item(OP_SAMPLE, 32'h00012345, 32'hFFFE8000);
      csr_write(CSR_OCTAVES, 32'd8);
      send_item(OP_SAMPLE, 32'h7FFFFFFF, 32'h80000000);
      send_item(OP_SAMPLE, 32'h00031234, 32'h00005678);
      csr_write(CSR_OCTAVES, 32'd15);
      send_item(OP_SAMPLE, 32'h80000000, 32'h7FFFFFFF);
      csr_write(CSR_SEED, 32'd0);
      send_item(OP_RESEED, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_item(OP_SAMPLE, 32'h00024000, 32'h00031000);
      csr_write(CSR_SEED, 32'hFFFFFFFF);
      csr_write(CSR_OCTAVES, 32'd1);
      send_item(OP_RESEED, 0, 0);
      send_item(OP_SAMPLE, 32'hFFFF0001, 32'h0000FFFF);
   endtask

   task automatic test_random_phases();
      int per_phase;
      per_phase = N_RANDOM / 8;
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_SEED, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFFFFFF : $urandom);
         csr_write(CSR_OCTAVES, (ph == 2) ? 32'd1 : (ph == 3) ? 32'd8 :
                                (ph == 4) ? 32'd15 : $urandom_range(0, 15));
         no_idle = (ph == 5);
         send_item(OP_RESEED, $urandom, $urandom);
         for (int k = 0; k < per_phase; k++) begin
            if (k == per_phase / 2) wait_drain();
            send_item(($urandom_range(0, 99) == 0) ? OP_RESEED : OP_SAMPLE,
                      rand_coord(), rand_coord());
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phases();
      wait_drain();
      repeat (400) @(posedge clock);
      $display("Covered %0d samples and %0d table rebuilds, %0d results checked.",
               n_samples, n_reseeds, n_checked);
      $display("Octave settings exercised (bit per value): %b", octaves_seen);
      if (errors == 0 && pending_noise.size() == 0) begin
         $display("perlin_noise_2d_fbm verification clean");
      end else begin
         $display("perlin_noise_2d_fbm verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pnf_pkg.sv
sv/pnf_div.sv
sv/perlin_noise_2d_fbm.sv
dv/tb_perlin_noise_2d_fbm.sv
